### src/mof_pkg.sv
package mof_pkg;

  localparam int WaitDepthDef = 8;
  localparam int TaskSlots    = 16;

  localparam int TaskW    = 4;
  localparam int OutcomeW = 3;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;

  localparam logic [OutcomeW-1:0] OutAcquired = 3'd0;
  localparam logic [OutcomeW-1:0] OutQueued   = 3'd1;
  localparam logic [OutcomeW-1:0] OutFull     = 3'd2;
  localparam logic [OutcomeW-1:0] OutFreed    = 3'd3;
  localparam logic [OutcomeW-1:0] OutHanded   = 3'd4;
  localparam logic [OutcomeW-1:0] OutIgnored  = 3'd5;

  localparam logic ActLock   = 1'b0;
  localparam logic ActUnlock = 1'b1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [TaskW-1:0]    waiters_now;
    logic [TaskW-1:0]    owner_now;
    logic                is_locked;
    logic [TaskW-1:0]    wake_task;
    logic                wake_valid;
    logic [OutcomeW-1:0] outcome;
  } result_t;

endpackage

### src/mof_cell.sv
module mof_cell (
  input  logic                     clk_i,
  input  mof_pkg::cell_ctrl_t      ctrl_i,
  input  logic [mof_pkg::TaskW-1:0] load_id_i,
  input  logic [mof_pkg::TaskW-1:0] next_id_i,
  output logic [mof_pkg::TaskW-1:0] id_o
);
  import mof_pkg::*;

  logic [TaskW-1:0] id_q, id_d;

  always_comb begin
    id_d = id_q;
    if (ctrl_i.shift) begin
      id_d = next_id_i;
    end else if (ctrl_i.load) begin
      id_d = load_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;

endmodule

### src/mutex_owner_fifo_handoff_top.sv
// Hardware mutex with a first-in first-out wait queue.
// Input stream s_axis: one item per lock or unlock request from a task id.
// Output stream m_axis: one result item per request, with the outcome, the
// task to wake on a handover, and the mutex state after the request.
// The wait queue is a row of WAIT_DEPTH cells; a push writes the cell at the
// fill count, a pop moves every cell one place toward the head.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle, set by the single result register;
// s_axis_tready stays high while the result register is empty or being taken.
// When the receiver stalls, the result holds and no new request is taken.
// Reset: the mutex is free, owner 0, queue empty, no result pending.
// Queue cells hold no reset value; only cells below the fill count are read.
// Task ids at or above TaskSlots wrap modulo TaskSlots.
module mutex_owner_fifo_handoff_top #(
  parameter int WAIT_DEPTH = mof_pkg::WaitDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mof_pkg::InDataW-1:0]   s_axis_tdata,  // action, task_id[3:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // outcome[2:0], wake_valid, wake_task[3:0], is_locked, owner_now[3:0],
  // waiters_now[3:0]
  output logic [mof_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mof_pkg::*;

  localparam int CntW = $clog2(WAIT_DEPTH + 1);
  localparam int ExtW = 8;

  logic             held_q, held_d;
  logic [TaskW-1:0] owner_q, owner_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q;
  result_t          res_q, res_d;

  logic             action;
  logic [TaskW-1:0] task_raw;
  logic [TaskW-1:0] tid;
  logic             accept;
  logic             push, pop;
  logic [ExtW-1:0]  cnt_ext;

  logic [TaskW-1:0] cell_id [WAIT_DEPTH];
  cell_ctrl_t       cell_ctrl [WAIT_DEPTH];

  assign action   = s_axis_tdata[0];
  assign task_raw = s_axis_tdata[TaskW:1];

  always_comb begin
    logic [8:0] r;
    r = 9'(task_raw);
    for (int k = 0; k < 8; k++) begin
      if (r >= 9'(TaskSlots)) begin
        r = r - 9'(TaskSlots);
      end
    end
    tid = r[TaskW-1:0];
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    held_d  = held_q;
    owner_d = owner_q;
    count_d = count_q;
    push    = 1'b0;
    pop     = 1'b0;
    res_d   = '0;
    if (action == ActLock) begin
      if (!held_q) begin
        held_d        = 1'b1;
        owner_d       = tid;
        res_d.outcome = OutAcquired;
      end else if (count_q != CntW'(WAIT_DEPTH)) begin
        push          = 1'b1;
        count_d       = count_q + 1'b1;
        res_d.outcome = OutQueued;
      end else begin
        res_d.outcome = OutFull;
      end
    end else begin
      if (held_q && owner_q == tid) begin
        if (count_q != '0) begin
          pop              = 1'b1;
          count_d          = count_q - 1'b1;
          owner_d          = cell_id[0];
          res_d.wake_valid = 1'b1;
          res_d.wake_task  = cell_id[0];
          res_d.outcome    = OutHanded;
        end else begin
          held_d        = 1'b0;
          owner_d       = '0;
          res_d.outcome = OutFreed;
        end
      end else begin
        res_d.outcome = OutIgnored;
      end
    end
    cnt_ext           = ExtW'(count_d);
    res_d.is_locked   = held_d;
    res_d.owner_now   = owner_d;
    res_d.waiters_now = (cnt_ext > ExtW'(15)) ? TaskW'(15) : cnt_ext[TaskW-1:0];
  end

  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    logic [TaskW-1:0] next_id;
    if (i == WAIT_DEPTH - 1) begin : g_tail
      assign next_id = '0;
    end else begin : g_mid
      assign next_id = cell_id[i+1];
    end
    assign cell_ctrl[i].shift = accept && pop;
    assign cell_ctrl[i].load  = accept && push && (count_q == CntW'(i));
    mof_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl[i]),
      .load_id_i (tid),
      .next_id_i (next_id),
      .id_o      (cell_id[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      owner_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        held_q  <= held_d;
        owner_q <= owner_d;
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

endmodule
